/* rtl/assert_macros.svh */
// assertion macros shared by the rtl modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, suspended while reset is low
`define SWB_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// clocked check that also holds during reset
`define SWB_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/swb_pkg.sv */
// shared types and constants of the sync word bitmap capture block
package swb_pkg;

	localparam int BYTE_W   = 8;
	localparam int COLUMN_W = 4;
	localparam int ROW_W    = 6;

	// configuration port
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 8;
	localparam logic [CFG_IDX_W-1:0] REG_SYNC_FIRST  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SYNC_SECOND = 1'd1;
	localparam logic [CFG_DATA_W-1:0] SYNC_FIRST_RST  = 8'h0B;
	localparam logic [CFG_DATA_W-1:0] SYNC_SECOND_RST = 8'hBB;

	// queue between front and back
	localparam int Q_DEPTH = 2;
	localparam int Q_PTR_W = 1;
	localparam int Q_CNT_W = 2;

	typedef logic [BYTE_W-1:0]   byte_t;
	typedef logic [COLUMN_W-1:0] column_t;
	typedef logic [ROW_W-1:0]    row_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage

/* rtl/swb_if.sv */
// request channel interfaces: received bytes in, tagged pixel bytes out
interface swb_in_if import swb_pkg::*; ();
	logic  valid;
	logic  ready;
	byte_t data_byte;

	modport source (output valid, output data_byte, input ready);
	modport sink (input valid, input data_byte, output ready);
endinterface

interface swb_out_if import swb_pkg::*; ();
	logic    valid;
	logic    ready;
	byte_t   pixel_bits;
	column_t byte_column;
	row_t    row;
	logic    frame_end;

	modport source (output valid, output pixel_bits, output byte_column, output row,
		output frame_end, input ready);
	modport sink (input valid, input pixel_bits, input byte_column, input row,
		input frame_end, output ready);
endinterface

/* rtl/swb_front.sv */
// front end: sync word hunt, payload length tracking and sync registers
`include "assert_macros.svh"
module swb_front import swb_pkg::*; #(
	parameter int ROW_BYTES = 10,
	parameter int ROWS      = 60
) (
	input  logic                  clk,
	input  logic                  arst_n,
	swb_in_if.sink                in_ch,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  q_stat_t               q_stat,
	output logic                  push,
	output byte_t                 push_data
);

	localparam int TOTAL = ROW_BYTES * ROWS;
	localparam int FW    = (TOTAL > 1) ? $clog2(TOTAL) : 1;

	typedef enum logic [1:0] {
		ST_HUNT,
		ST_FIRST,
		ST_PAYLOAD
	} state_t;

	state_t          state_q;
	logic [FW-1:0]   frame_q;
	byte_t           sync_first_q;
	byte_t           sync_second_q;
	logic            take;
	logic            last;

	assign in_ch.ready = !q_stat.full;
	assign take        = in_ch.valid && in_ch.ready;
	assign last        = (frame_q == FW'(TOTAL - 1));
	assign push        = take && (state_q == ST_PAYLOAD);
	assign push_data   = in_ch.data_byte;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_first_q  <= SYNC_FIRST_RST;
			sync_second_q <= SYNC_SECOND_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SYNC_FIRST:  sync_first_q  <= cfg_data;
				REG_SYNC_SECOND: sync_second_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_HUNT;
			frame_q <= '0;
		end else if (take) begin
			unique case (state_q)
				ST_PAYLOAD: begin
					if (last) begin
						state_q <= ST_HUNT;
						frame_q <= '0;
					end else begin
						frame_q <= frame_q + 1'b1;
					end
				end
				ST_FIRST: begin
					// second byte checked first so equal sync bytes complete the word
					if (in_ch.data_byte == sync_second_q) begin
						state_q <= ST_PAYLOAD;
						frame_q <= '0;
					end else if (in_ch.data_byte == sync_first_q) begin
						state_q <= ST_FIRST;
					end else begin
						state_q <= ST_HUNT;
					end
				end
				default: begin
					state_q <= (in_ch.data_byte == sync_first_q) ? ST_FIRST : ST_HUNT;
				end
			endcase
		end
	end

	`SWB_ASSERT(a_frame_done_hunts, (push && last) |=> (state_q == ST_HUNT),
		"front did not return to hunting after the last payload byte")
	`SWB_ASSERT(a_count_only_payload, (state_q != ST_PAYLOAD) |-> (frame_q == '0),
		"payload counter moved outside a frame")

endmodule

/* rtl/swb_queue.sv */
// short queue of payload bytes between front and back
`include "assert_macros.svh"
module swb_queue import swb_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  byte_t   push_data,
	input  logic    pop,
	output byte_t   pop_data,
	output q_stat_t q_stat
);

	byte_t              mem_q [Q_DEPTH];
	logic [Q_PTR_W-1:0] wr_ptr_q;
	logic [Q_PTR_W-1:0] rd_ptr_q;
	logic [Q_CNT_W-1:0] count_q;

	assign q_stat.full  = (count_q == Q_CNT_W'(Q_DEPTH));
	assign q_stat.empty = (count_q == '0);
	assign pop_data     = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	`SWB_ASSERT(a_count_bound, count_q <= Q_CNT_W'(Q_DEPTH),
		"queue holds more entries than its depth")

endmodule

/* rtl/swb_back.sv */
// back end: column and row tagging and the output register
`include "assert_macros.svh"
module swb_back import swb_pkg::*; #(
	parameter int ROW_BYTES = 10,
	parameter int ROWS      = 60
) (
	input  logic      clk,
	input  logic      arst_n,
	input  q_stat_t   q_stat,
	input  byte_t     pop_data,
	output logic      pop,
	swb_out_if.source out_ch
);

	localparam int CW = (ROW_BYTES > 1) ? $clog2(ROW_BYTES) : 1;
	localparam int RW = (ROWS > 1) ? $clog2(ROWS) : 1;

	logic [CW-1:0]          col_q;
	logic [RW-1:0]          row_q;
	logic [CW+COLUMN_W-1:0] col_ext;
	logic [RW+ROW_W-1:0]    row_ext;
	logic                   last_col;
	logic                   last_row;
	logic                   valid_q;
	byte_t                  pixel_q;
	column_t                column_q;
	row_t                   row_out_q;
	logic                   end_q;

	// counters reported masked to the field widths
	assign col_ext  = {{COLUMN_W{1'b0}}, col_q};
	assign row_ext  = {{ROW_W{1'b0}}, row_q};
	assign last_col = (col_q == CW'(ROW_BYTES - 1));
	assign last_row = (row_q == RW'(ROWS - 1));
	assign pop      = !q_stat.empty && (!valid_q || out_ch.ready);

	assign out_ch.valid       = valid_q;
	assign out_ch.pixel_bits  = pixel_q;
	assign out_ch.byte_column = column_q;
	assign out_ch.row         = row_out_q;
	assign out_ch.frame_end   = end_q;

	always_ff @(posedge clk) begin
		if (pop) begin
			pixel_q   <= pop_data;
			column_q  <= col_ext[COLUMN_W-1:0];
			row_out_q <= row_ext[ROW_W-1:0];
			end_q     <= last_col && last_row;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			col_q   <= '0;
			row_q   <= '0;
		end else begin
			if (pop) begin
				valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				valid_q <= 1'b0;
			end
			if (pop) begin
				if (last_col) begin
					col_q <= '0;
					row_q <= last_row ? '0 : row_q + 1'b1;
				end else begin
					col_q <= col_q + 1'b1;
				end
			end
		end
	end

	`SWB_ASSERT(a_frame_wraps, (pop && last_col && last_row) |=> (col_q == '0 && row_q == '0),
		"tag counters did not wrap after the last byte of a frame")
	`SWB_ASSERT(a_no_overwrite, (valid_q && !out_ch.ready) |-> !pop,
		"output register loaded while a request was still waiting")

endmodule

/* rtl/sync_word_bitmap_frame_capture.sv */
// top level of the sync word bitmap frame capture block
//
//  channel    dir  handshake        payload
//  in_ch      in   valid / ready    data_byte[7:0]
//  out_ch     out  valid / ready    pixel_bits[7:0] byte_column[3:0] row[5:0] frame_end
//  cfg        in   cfg_we only      cfg_index[0] cfg_data[7:0]
//
// one byte per cycle sustained while out_ch.ready stays high; a payload byte passes a queue
// entry, then the output register, before it is presented; bytes outside a frame give no request
// the front keeps taking bytes while the two-entry queue has room, so an output stall
// backs up into in_ch.ready only once the queue and the output register are full
// arst_n clears the hunt state, the tag counters, the queue and the output valid, and
// loads the sync registers with 0x0B and 0xBB; no clearing pass is needed
module sync_word_bitmap_frame_capture import swb_pkg::*; #(
	parameter int ROW_BYTES = 10,
	parameter int ROWS      = 60
) (
	input  logic                  clk,
	input  logic                  arst_n,
	swb_in_if.sink                in_ch,
	swb_out_if.source             out_ch,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	// front to queue
	logic    push;
	byte_t   push_data;
	// queue to back
	logic    pop;
	byte_t   pop_data;
	q_stat_t q_stat;

	// sync hunt and payload length; only payload bytes are pushed
	swb_front #(
		.ROW_BYTES (ROW_BYTES),
		.ROWS      (ROWS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.q_stat    (q_stat),
		.push      (push),
		.push_data (push_data)
	);

	// decouples the hunt from output stalls
	swb_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.pop_data  (pop_data),
		.q_stat    (q_stat)
	);

	// tags each byte with column and row, flags the last byte of the frame
	swb_back #(
		.ROW_BYTES (ROW_BYTES),
		.ROWS      (ROWS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_stat   (q_stat),
		.pop_data (pop_data),
		.pop      (pop),
		.out_ch   (out_ch)
	);

endmodule
